// ===== rtl/core/psalu_pkg.sv =====
// Package for the postfix stack ALU: request and status codes, queue entry type.
// No dependencies.
package psalu_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH = 3'd0,
		REQ_POP  = 3'd1,
		REQ_ADD  = 3'd2,
		REQ_SUB  = 3'd3,
		REQ_MUL  = 3'd4,
		REQ_DIV  = 3'd5,
		REQ_RDT  = 3'd6,
		REQ_RDB  = 3'd7
	} req_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_FEW     = 3'd3,
		ST_DIVZERO = 3'd4,
		ST_RANGE   = 3'd5
	} status_t;

	typedef struct packed {
		req_t        kind;
		logic [31:0] value;
		logic [9:0]  position;
	} cmd_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_RD1,
		EX_RD2,
		EX_MUL,
		EX_DIV,
		EX_FIN
	} ex_state_t;

endpackage

// ===== rtl/core/psalu_front.sv =====
// Front end of the postfix stack ALU: accepts requests into a two-entry queue.
// Depends on psalu_pkg.
module psalu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       req_type,
	input  logic [31:0]      push_value,
	input  logic [9:0]       position,
	output logic             busy,
	output logic             cmd_valid,
	output psalu_pkg::cmd_t  cmd,
	input  logic             cmd_take
);
	import psalu_pkg::*;

	cmd_t       fifo_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign busy      = cnt_q[1];
	assign push      = start && !busy;
	assign cmd_valid = cnt_q != 2'd0;
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= '{kind: req_t'(req_type), value: push_value, position: position};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/core/psalu_div.sv =====
// Iterative signed floor divider, one quotient bit per cycle.
// No dependencies.
module psalu_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quot
);
	logic [31:0] a_q, b_q, q_q;
	logic [32:0] r_q;
	logic [5:0]  n_q;
	logic        run_q, negq_q;
	logic [32:0] trial;
	logic [31:0] tq;

	assign trial = {r_q[31:0], a_q[31]} - {1'b0, b_q};
	assign tq    = negq_q ? (~q_q + 32'd1) : q_q;
	assign done  = run_q && n_q == 6'd32;
	assign quot  = (negq_q && r_q != 33'd0) ? tq - 32'd1 : tq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			n_q   <= 6'd0;
		end else if (go) begin
			run_q <= 1'b1;
			n_q   <= 6'd0;
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			n_q <= n_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q    <= num[31] ? (~num + 32'd1) : num;
			b_q    <= den[31] ? (~den + 32'd1) : den;
			negq_q <= num[31] ^ den[31];
			r_q    <= 33'd0;
			q_q    <= 32'd0;
		end else if (run_q && !done) begin
			a_q <= {a_q[30:0], 1'b0};
			if (!trial[32]) begin
				r_q <= trial;
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= {r_q[31:0], a_q[31]};
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

endmodule

// ===== rtl/core/psalu_back.sv =====
// Back end of the postfix stack ALU: stack memory, operand reads and execution.
// Depends on psalu_pkg and psalu_div.
module psalu_back #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  psalu_pkg::cmd_t  cmd,
	output logic             cmd_take,
	output logic             done,
	output logic [31:0]      result_value,
	output logic [2:0]       status,
	output logic [10:0]      fill_level
);
	import psalu_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = AW + 1;
	localparam int PW = (CW > 10) ? CW : 10;

	logic [31:0]   mem [STACK_DEPTH];
	logic [31:0]   rdata_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;

	ex_state_t state_q, state_d;
	cmd_t      c_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [31:0]   top_q, res_q, res_d;
	logic [2:0]    st_q, st_d;
	logic          done_q, done_d;
	logic [PW-1:0] pos_ext;
	logic [63:0]   prod;
	logic          div_go, div_done;
	logic [31:0]   div_q;
	logic          lat_top, lat_res;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	psalu_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(rdata_q), .den(top_q),
		.done(div_done), .quot(div_q)
	);

	assign pos_ext      = PW'(cmd.position);
	assign prod         = rdata_q * top_q;
	assign done         = done_q;
	assign result_value = res_q;
	assign status       = st_q;
	assign fill_level   = 11'(cnt_q);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		res_d    = res_q;
		st_d     = st_q;
		done_d   = 1'b0;
		cmd_take = 1'b0;
		we       = 1'b0;
		waddr    = AW'(cnt_q);
		wdata    = cmd.value;
		raddr    = AW'(cnt_q - CW'(1));
		div_go   = 1'b0;
		lat_top  = 1'b0;
		lat_res  = 1'b0;
		unique case (state_q)
			EX_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					res_d    = 32'd0;
					st_d     = ST_OK;
					unique case (cmd.kind)
						REQ_PUSH: begin
							if (cnt_q < CW'(STACK_DEPTH)) begin
								we    = 1'b1;
								cnt_d = cnt_q + CW'(1);
							end else st_d = ST_FULL;
							done_d = 1'b1;
						end
						REQ_POP: begin
							if (cnt_q != '0) state_d = EX_RD1;
							else begin
								st_d = ST_EMPTY; done_d = 1'b1;
							end
						end
						REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
							if (cnt_q < CW'(2)) begin
								st_d = ST_FEW; done_d = 1'b1;
							end else state_d = EX_RD1;
						end
						default: begin
							if (pos_ext >= PW'(cnt_q)) begin
								st_d = ST_RANGE; done_d = 1'b1;
							end else begin
								if (cmd.kind == REQ_RDT)
									raddr = AW'(PW'(cnt_q) - pos_ext - PW'(1));
								else raddr = AW'(pos_ext);
								state_d = EX_RD2;
							end
						end
					endcase
				end
			end
			EX_RD1: begin
				if (c_q.kind == REQ_POP) begin
					res_d   = rdata_q;
					cnt_d   = cnt_q - CW'(1);
					done_d  = 1'b1;
					state_d = EX_IDLE;
				end else begin
					lat_top = 1'b1;
					raddr   = AW'(cnt_q - CW'(2));
					state_d = EX_RD2;
				end
			end
			EX_RD2: begin
				if (c_q.kind == REQ_RDT || c_q.kind == REQ_RDB) begin
					res_d   = rdata_q;
					done_d  = 1'b1;
					state_d = EX_IDLE;
				end else if (c_q.kind == REQ_ADD) begin
					res_d = rdata_q + top_q; state_d = EX_FIN;
				end else if (c_q.kind == REQ_SUB) begin
					res_d = rdata_q - top_q; state_d = EX_FIN;
				end else if (c_q.kind == REQ_MUL) begin
					res_d = prod[31:0]; state_d = EX_FIN;
				end else if (top_q == 32'd0) begin
					st_d = ST_DIVZERO; done_d = 1'b1; state_d = EX_IDLE;
				end else begin
					div_go = 1'b1; state_d = EX_DIV;
				end
			end
			EX_DIV: begin
				if (div_done) begin
					res_d = div_q; state_d = EX_FIN;
				end
			end
			EX_FIN: begin
				we      = 1'b1;
				waddr   = AW'(cnt_q - CW'(2));
				wdata   = res_q;
				cnt_d   = cnt_q - CW'(1);
				done_d  = 1'b1;
				state_d = EX_IDLE;
			end
			default: state_d = EX_IDLE;
		endcase
		lat_res = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) c_q <= cmd;
		if (lat_top || lat_res) top_q <= rdata_q;
		res_q <= res_d;
		st_q  <= st_d;
	end

endmodule

// ===== rtl/core/postfix_stack_alu.sv =====
// Top level of the postfix stack ALU: request queue front end and stack back end.
// Depends on psalu_pkg, psalu_front and psalu_back.
//
// A request is taken at a rising edge with start high and busy low; a queue of
// two requests sits between the front end and the back end. Each request gives
// exactly one result, shown for one cycle while done is high, with
// result_value, status and fill_level. The receiver cannot stall.
// Push and errors found from the fill count finish in the idle state; pop and
// reads read the stack once; add, subtract and multiply read both operands
// and write the result back; divide by zero ends once both are read, and
// divide also waits on the one-bit-per-cycle divider. The stack memory has a
// single registered read port, so operands are read one after another.
// Sustained rate: one push every cycle while no other request holds the back end.
// Reset empties the stack at once; no clearing pass is made, since entries
// above the fill level are never read.
module postfix_stack_alu #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  req_type,
	input  logic [31:0] push_value,
	input  logic [9:0]  position,
	output logic        busy,
	output logic        done,
	output logic [31:0] result_value,
	output logic [2:0]  status,
	output logic [10:0] fill_level
);
	import psalu_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_take;

	psalu_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req_type),
		.push_value(push_value), .position(position), .busy(busy),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	psalu_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .done(done), .result_value(result_value),
		.status(status), .fill_level(fill_level)
	);

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for postfix_stack_alu: random and directed stack requests,
// predicted in a local stack copy and compared with each done strobe. Uses psalu_pkg.
module tb;
	import psalu_pkg::*;

	typedef struct {
		req_t        kind;
		logic [31:0] value;
		logic [9:0]  position;
		int          gap;
	} request_t;

	typedef struct {
		logic [31:0] value;
		status_t     code;
		logic [10:0] level;
	} outcome_t;

	localparam int DEPTH = 1024;
	localparam int IDLE_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [2:0]  req_type;
	logic [31:0] push_value;
	logic [9:0]  position;
	logic        busy;
	logic        done;
	logic [31:0] result_value;
	logic [2:0]  status;
	logic [10:0] fill_level;

	request_t    pending_requests[$];
	outcome_t    expected_outcomes[$];
	logic [31:0] model_stack[DEPTH];
	int          model_count;
	int          error_count;
	int          accepted_count;
	int          result_count;
	int          idle_cycles;
	int          gap_left;
	bit          stimulus_done;

	postfix_stack_alu uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req_type),
		.push_value(push_value), .position(position), .busy(busy), .done(done),
		.result_value(result_value), .status(status), .fill_level(fill_level)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] floor_quotient(logic [31:0] left, logic [31:0] right);
		longint a;
		longint b;
		longint q;
		longint r;
		a = longint'($signed(left));
		b = longint'($signed(right));
		q = a / b;
		r = a % b;
		if (r != 0 && ((r < 0) != (b < 0)))
			q = q - 1;
		return q[31:0];
	endfunction

	function automatic outcome_t apply_request(request_t rq);
		outcome_t    o;
		logic [31:0] top;
		logic [31:0] below;
		o.value = '0;
		o.code = ST_OK;
		case (rq.kind)
			REQ_PUSH: begin
				if (model_count < DEPTH) begin
					model_stack[model_count] = rq.value;
					model_count++;
				end else
					o.code = ST_FULL;
			end
			REQ_POP: begin
				if (model_count > 0) begin
					model_count--;
					o.value = model_stack[model_count];
				end else
					o.code = ST_EMPTY;
			end
			REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
				if (model_count < 2)
					o.code = ST_FEW;
				else begin
					top = model_stack[model_count - 1];
					below = model_stack[model_count - 2];
					case (rq.kind)
						REQ_ADD: o.value = below + top;
						REQ_SUB: o.value = below - top;
						REQ_MUL: o.value = below * top;
						default: begin
							if (top == 0)
								o.code = ST_DIVZERO;
							else
								o.value = floor_quotient(below, top);
						end
					endcase
					if (o.code == ST_OK) begin
						model_count--;
						model_stack[model_count - 1] = o.value;
					end
				end
			end
			default: begin
				if (rq.position >= model_count)
					o.code = ST_RANGE;
				else if (rq.kind == REQ_RDT)
					o.value = model_stack[model_count - rq.position - 1];
				else
					o.value = model_stack[rq.position];
			end
		endcase
		o.level = model_count[10:0];
		return o;
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'(int'($urandom_range(0, 20)) - 10);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_request(req_t kind, logic [31:0] value, logic [9:0] pos);
		request_t rq;
		rq.kind = kind;
		rq.value = value;
		rq.position = pos;
		rq.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
		pending_requests.push_back(rq);
	endtask

	// Driver: holds each request until it is taken, then waits the gap drawn for the next request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				accepted_count <= accepted_count + 1;
				expected_outcomes.push_back(apply_request(pending_requests.pop_front()));
			end
			if (start && busy) begin
			end else if (gap_left > 0 || (start && !busy && pending_requests.size() > 0 &&
			    pending_requests[0].gap > 0)) begin
				start <= 1'b0;
				gap_left <= (gap_left > 0) ? gap_left - 1 : pending_requests[0].gap - 1;
			end else if (pending_requests.size() > 0) begin
				start <= 1'b1;
				req_type <= pending_requests[0].kind;
				push_value <= pending_requests[0].value;
				position <= pending_requests[0].position;
			end else
				start <= 1'b0;
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (arst_n && done) begin
			outcome_t e;
			result_count <= result_count + 1;
			if (expected_outcomes.size() == 0) begin
				$error("unexpected result: value %h status %0d", result_value, status);
				error_count++;
			end else begin
				e = expected_outcomes.pop_front();
				if (result_value !== e.value) begin
					$error("result_value expected %h actual %h", e.value, result_value);
					error_count++;
				end
				if (status !== e.code) begin
					$error("status expected %0d actual %0d", e.code, status);
					error_count++;
				end
				if (fill_level !== e.level) begin
					$error("fill_level expected %0d actual %0d", e.level, fill_level);
					error_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else if (!stimulus_done) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		req_t k;
		start = 1'b0;
		req_type = '0;
		push_value = '0;
		position = '0;
		arst_n = 1'b0;
		model_count = 0;
		error_count = 0;
		accepted_count = 0;
		result_count = 0;
		idle_cycles = 0;
		stimulus_done = 1'b0;

		queue_request(REQ_POP, 32'h0, 10'd0);
		queue_request(REQ_ADD, 32'h0, 10'd0);
		queue_request(REQ_RDT, 32'h0, 10'd0);
		queue_request(REQ_RDB, 32'h0, 10'd1023);
		queue_request(REQ_PUSH, 32'h8000_0000, 10'd0);
		queue_request(REQ_DIV, 32'h0, 10'd0);
		queue_request(REQ_PUSH, 32'hffff_ffff, 10'd0);
		queue_request(REQ_DIV, 32'h0, 10'd0);
		queue_request(REQ_PUSH, 32'h0, 10'd0);
		queue_request(REQ_DIV, 32'h0, 10'd0);
		queue_request(REQ_RDT, 32'h0, 10'd1);
		queue_request(REQ_RDB, 32'h0, 10'd2);
		queue_request(REQ_POP, 32'h0, 10'd0);
		queue_request(REQ_PUSH, 32'd7, 10'd0);
		queue_request(REQ_PUSH, 32'hffff_fffe, 10'd0);
		queue_request(REQ_DIV, 32'h0, 10'd0);
		queue_request(REQ_PUSH, 32'h7fff_ffff, 10'd0);
		queue_request(REQ_MUL, 32'h0, 10'd0);
		queue_request(REQ_PUSH, 32'h7fff_ffff, 10'd0);
		queue_request(REQ_ADD, 32'h0, 10'd0);
		queue_request(REQ_PUSH, 32'd3, 10'd0);
		queue_request(REQ_SUB, 32'h0, 10'd0);
		queue_request(REQ_RDB, 32'h0, 10'd0);

		// Fill the stack until pushes overflow and read the far ends.
		for (int i = 0; i < DEPTH; i++)
			queue_request(REQ_PUSH, (i == 5) ? 32'h0 : random_word(), 10'd0);
		queue_request(REQ_PUSH, 32'h1234_5678, 10'd0);
		queue_request(REQ_RDT, 32'h0, 10'd1023);
		queue_request(REQ_RDB, 32'h0, 10'd1023);
		queue_request(REQ_DIV, 32'h0, 10'd0);
		for (int i = 0; i < 40; i++)
			queue_request(req_t'($urandom_range(2, 5)), 32'h0, 10'($urandom));

		// Random mix of all kinds on the deep stack.
		for (int i = 0; i < 310; i++) begin
			k = req_t'($urandom_range(0, 7));
			queue_request(k, random_word(),
			    ($urandom_range(0, 1) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15)));
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_requests.size() == 0 && !start);
		wait (expected_outcomes.size() == 0);
		stimulus_done = 1'b1;
		repeat (50) @(posedge clk);
		$display("Ran %0d requests covering every request kind, full and empty stack,",
		    accepted_count);
		$display("division corner cases and out-of-range reads; %0d results checked.",
		    result_count);
		if (error_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end
endmodule
